// ===== design/atgl_pkg.sv =====
package atgl_pkg;

  // Table sizes and cursor stepping.
  localparam int unsigned GLYPH_SLOTS = 222;
  localparam int unsigned FONT_COUNT  = 4;
  localparam int unsigned TAB_WIDTH   = 8;
  localparam int unsigned VTAB_ROWS   = 6;

  localparam int unsigned SLOT_W     = $clog2(GLYPH_SLOTS);
  localparam int unsigned FIDX_W     = 2;
  localparam int unsigned FONT_SLOTS = 2 ** FIDX_W;
  localparam int unsigned TMOD_W     = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int unsigned VMOD_W     = (VTAB_ROWS > 1) ? $clog2(VTAB_ROWS) : 1;

  localparam logic [TMOD_W-1:0] TAB_LAST  = TMOD_W'(TAB_WIDTH - 1);
  localparam logic [VMOD_W-1:0] VTAB_LAST = VMOD_W'(VTAB_ROWS - 1);

  // Character codes.
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CTRL_LAST  = 8'h1F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] FIRST_CODE = 8'd33;
  localparam logic [7:0] LAST_CODE  = 8'(33 + GLYPH_SLOTS - 1);

  // Register addresses on the configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_ORIGIN_X = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_ORIGIN_Y = 3'd4;

  typedef enum logic [1:0] {
    FUNC_GLYPH = 2'd0,
    FUNC_FONT  = 2'd1,
    FUNC_CHAR  = 2'd2
  } atgl_func_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        code;
    logic              start_req;
    logic [FIDX_W-1:0] font_index;
    logic [15:0]       field_ax;
    logic [15:0]       field_ay;
    logic [15:0]       field_bx;
    logic [15:0]       field_by;
    logic [15:0]       offset_x;
    logic [15:0]       offset_y;
    logic [15:0]       texture_id;
  } atgl_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [15:0]        quad_width;
    logic [15:0]        quad_height;
    logic [15:0]        atlas_x;
    logic [15:0]        atlas_y;
    logic [15:0]        texture;
  } atgl_out_t;

  typedef struct packed {
    logic [15:0]       atlas_x;
    logic [15:0]       atlas_y;
    logic [15:0]       width;
    logic [15:0]       height;
    logic [15:0]       off_x;
    logic [15:0]       off_y;
    logic [FIDX_W-1:0] font;
  } glyph_t;

  typedef struct packed {
    logic [15:0] cell_w;
    logic [15:0] cell_h;
    logic [15:0] gap_w;
    logic [15:0] gap_h;
    logic [15:0] texture;
  } font_t;

  // Pipeline enables handed from the top level to the quad stages.
  typedef struct packed {
    logic b_load;
    logic out_load;
  } atgl_pipe_t;

  function automatic logic atgl_is_unknown(input logic [7:0] code);
    return !(code inside {[FIRST_CODE:LAST_CODE]});
  endfunction

  function automatic logic [SLOT_W-1:0] atgl_slot(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - FIRST_CODE;
    return SLOT_W'(diff);
  endfunction

  // A character transaction that produces a quad.
  function automatic logic atgl_is_draw(input atgl_in_t item);
    return (item.func == FUNC_CHAR) &&
           !(item.code inside {[8'h00:CTRL_LAST], CH_DEL, CH_SPACE});
  endfunction

endpackage

// ===== design/atgl_cursor.sv =====
module atgl_cursor
  import atgl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  atgl_in_t    item_i,
  output logic [15:0] col_o,
  output logic [15:0] row_o
);

  // Alongside each coordinate we keep its remainder modulo the tab stop,
  // so tabbing needs no divider.
  logic [15:0]       col_q, col_d, col_b;
  logic [15:0]       row_q, row_d, row_b;
  logic [TMOD_W-1:0] cmod_q, cmod_d, cmod_b;
  logic [VMOD_W-1:0] rmod_q, rmod_d, rmod_b;
  logic [16:0]       tab_sum, vt_sum;
  logic              is_char, start;

  assign is_char = (item_i.func == FUNC_CHAR);
  assign start   = is_char && item_i.start_req;

  always_comb begin
    col_b  = start ? '0 : col_q;
    cmod_b = start ? '0 : cmod_q;
    row_b  = start ? '0 : row_q;
    rmod_b = start ? '0 : rmod_q;

    tab_sum = 17'(col_b) - 17'(cmod_b) + 17'(TAB_WIDTH);
    vt_sum  = 17'(row_b) - 17'(rmod_b) + 17'(VTAB_ROWS);

    col_d  = col_q;
    cmod_d = cmod_q;
    row_d  = row_q;
    rmod_d = rmod_q;

    if (acc_i && is_char) begin
      col_d  = col_b;
      cmod_d = cmod_b;
      row_d  = row_b;
      rmod_d = rmod_b;
      if (item_i.code inside {[8'h00:CTRL_LAST], CH_DEL}) begin
        case (item_i.code)
          CH_BS: begin
            if (col_b != '0) begin
              col_d  = col_b - 16'd1;
              cmod_d = (cmod_b == '0) ? TAB_LAST : cmod_b - TMOD_W'(1);
            end
          end
          CH_TAB: begin
            // A wrapped stop lands below one tab width, so it is its own remainder.
            col_d  = tab_sum[15:0];
            cmod_d = tab_sum[16] ? tab_sum[TMOD_W-1:0] : '0;
          end
          CH_LF: begin
            col_d  = '0;
            cmod_d = '0;
            if (row_b == 16'hFFFF) begin
              row_d  = '0;
              rmod_d = '0;
            end else begin
              row_d  = row_b + 16'd1;
              rmod_d = (rmod_b == VTAB_LAST) ? '0 : rmod_b + VMOD_W'(1);
            end
          end
          CH_VT: begin
            row_d  = vt_sum[15:0];
            rmod_d = vt_sum[16] ? vt_sum[VMOD_W-1:0] : '0;
          end
          CH_CR: begin
            col_d  = '0;
            cmod_d = '0;
          end
          default: begin
          end
        endcase
      end else begin
        if (col_b == 16'hFFFF) begin
          col_d  = '0;
          cmod_d = '0;
        end else begin
          col_d  = col_b + 16'd1;
          cmod_d = (cmod_b == TAB_LAST) ? '0 : cmod_b + TMOD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      cmod_q <= '0;
      row_q  <= '0;
      rmod_q <= '0;
    end else begin
      col_q  <= col_d;
      cmod_q <= cmod_d;
      row_q  <= row_d;
      rmod_q <= rmod_d;
    end
  end

  assign col_o = col_b;
  assign row_o = row_b;

endmodule

// ===== design/atgl_tables.sv =====
module atgl_tables
  import atgl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     acc_i,
  input  atgl_in_t item_i,
  output glyph_t   glyph_o,
  output font_t    font_o
);

  glyph_t             mem_q [GLYPH_SLOTS];
  logic [GLYPH_SLOTS-1:0] valid_q;
  glyph_t             unk_q;
  glyph_t             rd_q;
  logic               rd_valid_q;
  logic               rd_unk_q;
  glyph_t             wr_entry;
  logic [SLOT_W-1:0]  slot;
  logic               unk;
  logic               glyph_we;
  logic               use_mem;
  font_t              font_tbl [FONT_SLOTS];

  assign slot     = atgl_slot(item_i.code);
  assign unk      = atgl_is_unknown(item_i.code);
  assign glyph_we = acc_i && (item_i.func == FUNC_GLYPH);

  assign wr_entry = '{atlas_x: item_i.field_ax, atlas_y: item_i.field_ay,
                      width:   item_i.field_bx, height:  item_i.field_by,
                      off_x:   item_i.offset_x, off_y:   item_i.offset_y,
                      font:    item_i.font_index};

  always_ff @(posedge clk_i) begin
    if (glyph_we && !unk) begin
      mem_q[slot] <= wr_entry;
    end
    if (acc_i) begin
      rd_q <= mem_q[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      unk_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_unk_q   <= 1'b1;
    end else begin
      if (glyph_we && !unk) begin
        valid_q[slot] <= 1'b1;
      end
      if (glyph_we && unk) begin
        unk_q <= wr_entry;
      end
      if (acc_i) begin
        rd_valid_q <= valid_q[slot];
        rd_unk_q   <= unk;
      end
    end
  end

  // An empty entry (zero size) falls back on the unknown glyph.
  assign use_mem = !rd_unk_q && rd_valid_q && ({rd_q.width, rd_q.height} != '0);
  assign glyph_o = use_mem ? rd_q : unk_q;

  for (genvar i = 0; i < FONT_SLOTS; i++) begin : g_font
    if (i < FONT_COUNT) begin : g_used
      font_t ent_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ent_q <= '0;
        end else if (acc_i && item_i.func == FUNC_FONT &&
                     item_i.font_index == FIDX_W'(i)) begin
          ent_q <= '{cell_w: item_i.field_ax, cell_h: item_i.field_ay,
                     gap_w:  item_i.field_bx, gap_h:  item_i.field_by,
                     texture: item_i.texture_id};
        end
      end
      assign font_tbl[i] = ent_q;
    end else begin : g_unused
      assign font_tbl[i] = '0;
    end
  end

  assign font_o = font_tbl[glyph_o.font];

endmodule

// ===== design/atgl_quad.sv =====
module atgl_quad
  import atgl_pkg::*;
(
  input  logic        clk_i,
  input  atgl_pipe_t  pipe_i,
  input  glyph_t      glyph_i,
  input  font_t       font_i,
  input  logic [15:0] col_i,
  input  logic [15:0] row_i,
  input  logic [31:0] origin_x_i,
  input  logic [31:0] origin_y_i,
  output atgl_out_t   quad_o
);

  logic [15:0] b_col_q, b_row_q;
  logic [16:0] b_pitch_x_q, b_pitch_y_q;
  glyph_t      b_glyph_q;
  logic [15:0] b_tex_q;
  logic [32:0] prod_x, prod_y;
  logic [31:0] sx, sy;
  atgl_out_t   out_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.b_load) begin
      b_col_q     <= col_i;
      b_row_q     <= row_i;
      b_pitch_x_q <= 17'(font_i.cell_w) + 17'(font_i.gap_w);
      b_pitch_y_q <= 17'(font_i.cell_h) + 17'(font_i.gap_h);
      b_glyph_q   <= glyph_i;
      b_tex_q     <= font_i.texture;
    end
  end

  assign prod_x = b_col_q * b_pitch_x_q;
  assign prod_y = b_row_q * b_pitch_y_q;
  assign sx = origin_x_i + prod_x[31:0] + 32'(b_glyph_q.off_x);
  assign sy = origin_y_i - (prod_y[31:0] + 32'(b_glyph_q.height) + 32'(b_glyph_q.off_y));

  always_ff @(posedge clk_i) begin
    if (pipe_i.out_load) begin
      out_q.screen_x    <= sx;
      out_q.screen_y    <= sy;
      out_q.quad_width  <= b_glyph_q.width;
      out_q.quad_height <= b_glyph_q.height;
      out_q.atlas_x     <= b_glyph_q.atlas_x;
      out_q.atlas_y     <= b_glyph_q.atlas_y;
      out_q.texture     <= b_tex_q;
    end
  end

  assign quad_o = out_q;

endmodule

// ===== design/ascii_text_glyph_layout.sv =====
// A drawing character transaction is registered into the first stage (table read) when
// accepted, then into the second stage (font lookup), then the output register (position).
// Throughput: one per cycle unless out_stall_i is set; the three stages advance independently.
// Reset (asynchronous, active low) zeroes the cursor, origins, glyph valid bits,
// unknown glyph and font table; the glyph memory itself needs no clearing pass.
module ascii_text_glyph_layout
  import atgl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  atgl_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output atgl_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers. The low address bits are not decoded,
  // so the register is chosen by the word address bit.
  logic [31:0] origin_x_q, origin_y_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_ORIGIN_Y[2]) ? origin_y_q : origin_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == ADDR_ORIGIN_Y[2]) begin
        origin_y_q <= pwdata;
      end else begin
        origin_x_q <= pwdata;
      end
    end
  end

  // Pipeline control. Every stage has its own valid bit and loads whenever
  // it is empty or its contents move on, so a waiting result in the output
  // register still lets two more transactions enter behind it. Only drawing
  // characters occupy a stage; table writes and cursor moves finish on the
  // edge at which they are accepted.
  logic       a_v_q, b_v_q, out_v_q;
  logic       adv_a, adv_b, adv_out;
  logic       in_acc, draw;
  logic [15:0] a_col_q, a_row_q;
  logic [15:0] cur_col, cur_row;
  atgl_pipe_t pipe;
  glyph_t     glyph;
  font_t      font;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv_b      = !b_v_q || adv_out;
  assign adv_a      = !a_v_q || adv_b;
  assign in_stall_o = !adv_a;
  assign in_acc     = in_valid_i && adv_a;
  assign draw       = atgl_is_draw(in_data_i);

  assign pipe.b_load   = adv_b && a_v_q;
  assign pipe.out_load = adv_out && b_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_v_q <= in_acc && draw;
      end
      if (adv_b) begin
        b_v_q <= a_v_q;
      end
      if (adv_out) begin
        out_v_q <= b_v_q;
      end
    end
  end

  // The cursor moves on the accepting edge; the position that this character
  // is drawn at travels with it through the first stage.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_col_q <= cur_col;
      a_row_q <= cur_row;
    end
  end

  atgl_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .item_i (in_data_i),
    .col_o  (cur_col),
    .row_o  (cur_row)
  );

  // Glyph memory read is registered on the accepting edge; the unknown glyph
  // and the font table are flip-flops read in the first stage. A table write
  // accepted later than a character always lands after that character has
  // read it, so the transaction order is kept.
  atgl_tables u_tables (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (in_acc),
    .item_i  (in_data_i),
    .glyph_o (glyph),
    .font_o  (font)
  );

  // Second stage holds the pitches; the output stage does one 16 by 17 bit
  // multiply per axis and the additions into the result register.
  atgl_quad u_quad (
    .clk_i      (clk_i),
    .pipe_i     (pipe),
    .glyph_i    (glyph),
    .font_i     (font),
    .col_i      (a_col_q),
    .row_i      (a_row_q),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .quad_o     (out_data_o)
  );

  assign out_valid_o = out_v_q;

`ifndef SYNTH
  // The input only stalls when every stage holds a result and the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_v_q && b_v_q && out_v_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A stage is filled by an accepted transaction exactly when it draws.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (a_v_q == $past(draw)))
    else $error("first stage occupancy does not follow the accepted character");

  // A result moving out of the second stage appears at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe.out_load |=> out_valid_o)
    else $error("result lost between second stage and output register");
`endif

endmodule
